/* src/rans64_pkg.sv */
`default_nettype none
package rans64_pkg;

    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int START_W = 14;
    localparam int FREQ_W  = 15;
    localparam int WORD_W  = 32;
    localparam int STATE_W = 64;
    localparam int REM_W   = FREQ_W + 1;
    localparam int CNT_W   = 6;

    localparam logic [STATE_W-1:0] LOWER_BOUND = 64'h0000_0000_8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [FREQ_W-1:0]  freq;
    } sym_entry_t;

endpackage
`default_nettype wire

/* src/rans64_ram.sv */
`default_nettype none
module rans64_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* src/rans64_symbol_encoder_core.sv */
`default_nettype none
// rANS encoder, 64-bit state, 32-bit word renormalization.
// input channel (s_*): one beat is a command. load writes a symbol's start
//   and frequency into the symbol table, encode codes one symbol (feed
//   symbols last to first), flush emits the state's high then low word.
// output channel (m_*): one beat is a stream word, or a bad_symbol flag
//   when an encode finds a zero or oversized frequency or an index out of
//   range. m_last_word marks the second word of a flush.
// sequence: a load is written when accepted. an encode steps through table
//   read, lookup, renormalize, a 64-step restoring divide of the state by the
//   frequency, one quotient bit per cycle, and the state update. a flush steps
//   through accept, high word, low word. the divider sets the rate; one
//   command is in work at a time and s_ready is low meanwhile.
// the symbol table is a single-port-write ram with registered read, one
//   entry per symbol, undefined until loaded. no clearing pass.
// reset: state returns to 2^31, output beat dropped, table untouched.
// stall: a word waiting on m_ready holds the sequencer before it emits
//   the next beat; nothing is lost.
module rans64_symbol_encoder_core #(
    parameter int SCALE_BITS   = 14,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rans64_pkg::CMD_W-1:0]  s_command,
    input  wire logic [rans64_pkg::SYM_W-1:0]  s_symbol,
    input  wire logic [rans64_pkg::START_W-1:0] s_start_value,
    input  wire logic [rans64_pkg::FREQ_W-1:0] s_freq_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rans64_pkg::WORD_W-1:0] m_out_word,
    output logic                               m_last_word,
    output logic                               m_bad_symbol
);
    import rans64_pkg::*;

    localparam int AW = $clog2(SYMBOL_COUNT);
    localparam int EW = START_W + FREQ_W;
    localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W+1)'(SYMBOL_COUNT);
    localparam logic [16:0] FREQ_MAX = 17'(1) << SCALE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOKUP, ST_RENORM, ST_DIV, ST_UPDATE, ST_BAD, ST_FLUSH_HI, ST_FLUSH_LO
    } state_t;

    state_t             state_reg;
    logic [STATE_W-1:0] coder_reg;
    logic [STATE_W-1:0] div_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [START_W-1:0] start_reg;
    logic               m_valid_reg;
    logic [WORD_W-1:0]  m_word_reg;
    logic               m_last_reg;
    logic               m_bad_reg;

    logic               accept;
    logic               out_free;
    logic               sym_ok;
    sym_entry_t         wr_entry;
    sym_entry_t         rd_entry;
    logic [EW-1:0]      rd_bits;
    logic [REM_W-1:0]   rem_shift;
    logic               rem_ge;
    logic [STATE_W-1:0] x_top;
    logic               renorm_hit;
    logic               emit;
    logic [STATE_W-1:0] new_state;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign sym_ok   = {1'b0, s_symbol} < SYM_LIMIT;

    assign wr_entry.start = s_start_value;
    assign wr_entry.freq  = s_freq_value;
    assign rd_entry       = sym_entry_t'(rd_bits);

    rans64_ram #(
        .WIDTH (EW),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (accept && cmd_t'(s_command) == CMD_LOAD && sym_ok),
        .waddr (s_symbol[AW-1:0]),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (s_symbol[AW-1:0]),
        .rdata (rd_bits)
    );

    assign rem_shift  = {rem_reg[REM_W-2:0], div_reg[STATE_W-1]};
    assign rem_ge     = rem_shift >= {1'b0, freq_reg};
    assign x_top      = coder_reg >> (63 - SCALE_BITS);
    assign renorm_hit = x_top >= STATE_W'(freq_reg);
    assign new_state  = (div_reg << SCALE_BITS) + STATE_W'(rem_reg) + STATE_W'(start_reg);

    // a new beat is loaded into the output register this cycle
    assign emit = out_free && ((state_reg == ST_RENORM && renorm_hit) ||
                               state_reg == ST_BAD || state_reg == ST_FLUSH_HI ||
                               state_reg == ST_FLUSH_LO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            coder_reg   <= LOWER_BOUND;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (cmd_t'(s_command))
                            CMD_ENCODE: state_reg <= sym_ok ? ST_LOOKUP : ST_BAD;
                            CMD_FLUSH:  state_reg <= ST_FLUSH_HI;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_LOOKUP: begin
                    freq_reg  <= rd_entry.freq;
                    start_reg <= rd_entry.start;
                    if (rd_entry.freq == '0 || 17'(rd_entry.freq) > FREQ_MAX) begin
                        state_reg <= ST_BAD;
                    end else begin
                        state_reg <= ST_RENORM;
                    end
                end
                ST_RENORM: begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (renorm_hit) begin
                        if (out_free) begin
                            m_valid_reg <= 1'b1;
                            m_word_reg  <= coder_reg[WORD_W-1:0];
                            m_last_reg  <= 1'b0;
                            m_bad_reg   <= 1'b0;
                            div_reg     <= coder_reg >> WORD_W;
                            state_reg   <= ST_DIV;
                        end
                    end else begin
                        div_reg   <= coder_reg;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_ge ? rem_shift - {1'b0, freq_reg} : rem_shift;
                    div_reg <= {div_reg[STATE_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '1) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    coder_reg <= new_state;
                    state_reg <= ST_IDLE;
                end
                ST_BAD: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_word_reg  <= '0;
                        m_last_reg  <= 1'b0;
                        m_bad_reg   <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_FLUSH_HI: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_word_reg  <= coder_reg[STATE_W-1:WORD_W];
                        m_last_reg  <= 1'b0;
                        m_bad_reg   <= 1'b0;
                        state_reg   <= ST_FLUSH_LO;
                    end
                end
                ST_FLUSH_LO: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_word_reg  <= coder_reg[WORD_W-1:0];
                        m_last_reg  <= 1'b1;
                        m_bad_reg   <= 1'b0;
                        coder_reg   <= LOWER_BOUND;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_word   = m_word_reg;
    assign m_last_word  = m_last_reg;
    assign m_bad_symbol = m_bad_reg;

endmodule
`default_nettype wire

/* src/rans64_checker.sv */
`default_nettype none
module rans64_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_command,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_out_word,
    input wire logic        m_last_word,
    input wire logic        m_bad_symbol
);
    import rans64_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_word) && $stable(m_last_word))
        else $error("stalled output beat changed");

    // bad beat carries no word
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_symbol |-> m_out_word == '0 && !m_last_word)
        else $error("bad_symbol beat carries data");

    // reset drops the output beat
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // flush busies the input side
    a_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_FLUSH |=> !s_ready)
        else $error("input ready right after flush");

endmodule

bind rans64_symbol_encoder_core rans64_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_command    (s_command),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_word   (m_out_word),
    .m_last_word  (m_last_word),
    .m_bad_symbol (m_bad_symbol)
);
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rans64_pkg::*;

    localparam int LIMIT_CYCLES = 900000;
    localparam int SCALE_BITS   = 14;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              bad;
    } coded_word_t;

    class rans_scoreboard;
        logic [STATE_W-1:0] coder_x;
        logic [START_W-1:0] start_tab[256];
        logic [FREQ_W-1:0]  freq_tab[256];
        coded_word_t        pending_words[$];
        int                 errors;

        function new();
            coder_x = LOWER_BOUND;
            errors  = 0;
        endfunction

        function void push_word(logic [WORD_W-1:0] w, logic l, logic b);
            coded_word_t e;
            e.word = w;
            e.last = l;
            e.bad  = b;
            pending_words.push_back(e);
        endfunction

        function void note_beat(cmd_t cmd, logic [SYM_W-1:0] sym,
                                logic [START_W-1:0] st, logic [FREQ_W-1:0] fr);
            logic [STATE_W-1:0] x;
            logic [STATE_W-1:0] f;
            logic [STATE_W-1:0] limit;
            case (cmd)
                CMD_LOAD: begin
                    start_tab[sym] = st;
                    freq_tab[sym]  = fr;
                end
                CMD_ENCODE: begin
                    f = 64'(freq_tab[sym]);
                    x = coder_x;
                    if (f == 0 || f > (64'd1 << SCALE_BITS)) begin
                        push_word('0, 1'b0, 1'b1);
                    end else begin
                        limit = ((LOWER_BOUND >> SCALE_BITS) << 32) * f;
                        if (x >= limit) begin
                            push_word(x[31:0], 1'b0, 1'b0);
                            x = x >> 32;
                        end
                        coder_x = ((x / f) << SCALE_BITS) + (x % f) + 64'(start_tab[sym]);
                    end
                end
                CMD_FLUSH: begin
                    push_word(coder_x[63:32], 1'b0, 1'b0);
                    push_word(coder_x[31:0], 1'b1, 1'b0);
                    coder_x = LOWER_BOUND;
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("error: %s got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_word(logic [WORD_W-1:0] w, logic l, logic b);
            coded_word_t e;
            if (pending_words.size() == 0) begin
                report("unexpected beat, word", w, '0);
            end else begin
                e = pending_words.pop_front();
                if (w !== e.word) report("out_word", w, e.word);
                if (l !== e.last) report("last_word", 32'(l), 32'(e.last));
                if (b !== e.bad) report("bad_symbol", 32'(b), 32'(e.bad));
            end
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0]   s_command = '0;
    logic [SYM_W-1:0]   s_symbol = '0;
    logic [START_W-1:0] s_start_value = '0;
    logic [FREQ_W-1:0]  s_freq_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [WORD_W-1:0] m_out_word;
    logic m_last_word;
    logic m_bad_symbol;

    rans_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_off_left = 0;
    int  cycle_count = 0;
    bit  loaded[256];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rans64_symbol_encoder_core #(
        .SCALE_BITS(SCALE_BITS)
    ) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_symbol(s_symbol),
        .s_start_value(s_start_value), .s_freq_value(s_freq_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_word(m_out_word), .m_last_word(m_last_word),
        .m_bad_symbol(m_bad_symbol)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_out_word, m_last_word, m_bad_symbol);
    end

    // receiver, with a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (hold_off_left > 0) begin
            m_ready = 1'b0;
            hold_off_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task send_beat(cmd_t cmd, logic [SYM_W-1:0] sym,
                   logic [START_W-1:0] st, logic [FREQ_W-1:0] fr);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_command     = cmd;
        s_symbol      = sym;
        s_start_value = st;
        s_freq_value  = fr;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(cmd, sym, st, fr);
        if (cmd == CMD_LOAD) loaded[sym] = 1'b1;
    endtask

    task drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 8) return FREQ_W'($urandom_range(32767, 16385));
        if (r < 20) return FREQ_W'($urandom_range(16384, 8192));
        return FREQ_W'($urandom_range(16384, 1));
    endfunction

    task random_beat();
        int r;
        int sym;
        r = $urandom_range(99);
        sym = $urandom_range(255);
        while (!loaded[sym]) sym = $urandom_range(255);
        if (r < 10)
            send_beat(CMD_LOAD, SYM_W'($urandom_range(255)),
                      START_W'($urandom), pick_freq());
        else if (r < 18)
            send_beat(CMD_FLUSH, SYM_W'($urandom), START_W'($urandom), FREQ_W'($urandom));
        else if (r < 20)
            send_beat(CMD_NONE, SYM_W'($urandom), START_W'($urandom), FREQ_W'($urandom));
        else
            send_beat(CMD_ENCODE, SYM_W'(sym), START_W'($urandom), FREQ_W'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed
        send_beat(CMD_FLUSH, 8'd0, '0, '0);
        send_beat(CMD_LOAD, 8'd0, 14'd0, 15'd1);
        send_beat(CMD_LOAD, 8'd255, 14'd16383, 15'd16384);
        send_beat(CMD_LOAD, 8'd1, 14'd100, 15'd0);
        send_beat(CMD_LOAD, 8'd2, 14'd7, 15'd16385);
        send_beat(CMD_LOAD, 8'd3, 14'd8191, 15'd32767);
        send_beat(CMD_LOAD, 8'd4, 14'd5, 15'd3);
        send_beat(CMD_ENCODE, 8'd255, '0, '0);
        send_beat(CMD_ENCODE, 8'd1, '0, '0);
        send_beat(CMD_ENCODE, 8'd2, '0, '0);
        send_beat(CMD_ENCODE, 8'd3, '0, '0);
        send_beat(CMD_ENCODE, 8'd4, '0, '0);
        send_beat(CMD_NONE, 8'd255, 14'd16383, 15'd32767);
        repeat (5) send_beat(CMD_ENCODE, 8'd0, '0, '0);
        send_beat(CMD_ENCODE, 8'd255, '0, '0);
        send_beat(CMD_ENCODE, 8'd4, '0, '0);
        send_beat(CMD_FLUSH, 8'd0, '0, '0);
        drain();

        // fill the whole table
        for (int i = 0; i < 256; i++)
            send_beat(CMD_LOAD, SYM_W'(i), START_W'($urandom), pick_freq());

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 25 : 0;
            if (phase == 0) hold_off_left = 2000;
            for (int n = 0; n < 145; n++) begin
                random_beat();
                if (n == 72) drain();
            end
            drain();
        end

        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
